// File: rtl/wss_pkg.sv
`default_nettype none

package wss_pkg;

    localparam int GRID_MAX   = 63;
    localparam int VALUE_BITS = 32;
    localparam int GRID_BITS  = 6;
    localparam int COEF_BITS  = 16;
    localparam int GRID_RESET = 63;

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;

    localparam int IN_TDATA_W  = ((2 * VALUE_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((VALUE_BITS + 7) / 8) * 8;

    // grid geometry
    localparam int AXIS_W    = $clog2(GRID_MAX + 1);
    localparam int PLANE_MAX = (GRID_MAX + 1) * (GRID_MAX + 1);
    localparam int FILL_W    = $clog2(PLANE_MAX);
    localparam int PLEN_MAX  = GRID_MAX * (GRID_MAX + 1);
    localparam int PLEN_W    = $clog2(PLEN_MAX);
    localparam int ROW_W     = $clog2(GRID_MAX);

    localparam int RESET_N          = (GRID_RESET > GRID_MAX) ? GRID_MAX : GRID_RESET;
    localparam int RESET_PLANE_LAST = (RESET_N + 1) * (RESET_N + 1) - 1;
    localparam int RESET_PLEN_LAST  = RESET_N * (RESET_N + 1) - 1;
    localparam int RESET_ROW_LAST   = RESET_N - 1;

    // arithmetic widths
    localparam int PAIR_W = VALUE_BITS + 1;
    localparam int SUM_W  = VALUE_BITS + 3;
    localparam int LAP_W  = VALUE_BITS + 4;
    localparam int BASE_W = VALUE_BITS + 2;
    localparam int PROD_W = LAP_W + COEF_BITS + 1;
    localparam int R_W    = LAP_W + 1;
    localparam int ACC_W  = R_W + 1;

    localparam logic signed [VALUE_BITS-1:0] VALUE_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
    localparam logic signed [VALUE_BITS-1:0] VALUE_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_GRID_N     = 2'd0,
        CFG_COEF       = 2'd1,
        CFG_FIRST_STEP = 2'd2
    } t_cfg_idx;

    typedef logic signed [VALUE_BITS-1:0] t_value;

    // the seven stencil points of one center plus its previous value
    typedef struct packed {
        t_value up_plane;
        t_value up_row;
        t_value up_col;
        t_value center;
        t_value dn_col;
        t_value dn_row;
        t_value dn_plane;
        t_value prev;
    } t_taps;

    typedef struct packed {
        logic              shift;
        logic              clear;
        logic [PLEN_W-1:0] plane_last;
        logic [ROW_W-1:0]  row_last;
    } t_win_ctl;

    function automatic logic [AXIS_W-1:0] eff_grid(input logic [GRID_BITS-1:0] v);
        int w;
        w = int'(v);
        if (w < 2) w = 2;
        if (w > GRID_MAX) w = GRID_MAX;
        return AXIS_W'(w);
    endfunction

endpackage

`default_nettype wire

// File: rtl/wss_ram.sv
`default_nettype none

module wss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: rtl/wss_window.sv
`default_nettype none

// Raster-order delay lines. Each ring advances one entry per transfer; the read
// address runs one entry ahead so the old word is in the read register when
// the next transfer overwrites it.
module wss_window (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  wss_pkg::t_win_ctl i_ctl,
    input  wss_pkg::t_value   i_curr,
    input  wss_pkg::t_value   i_prev,
    output wss_pkg::t_taps    o_taps
);

    localparam int VB = wss_pkg::VALUE_BITS;

    logic [wss_pkg::PLEN_W-1:0] r_pptr, n_pptr;
    logic [wss_pkg::ROW_W-1:0]  r_rptr, n_rptr;
    logic [3*VB-1:0]            plane_wd, plane_rd;
    logic [3*VB-1:0]            row_wd, row_rd;
    wss_pkg::t_value            r_center, r_dn_col, r_prev_q;

    always_comb begin
        n_pptr = r_pptr;
        n_rptr = r_rptr;
        if (i_ctl.clear) begin
            n_pptr = '0;
            n_rptr = '0;
        end else if (i_ctl.shift) begin
            n_pptr = (r_pptr == i_ctl.plane_last) ? '0 : r_pptr + 1'b1;
            n_rptr = (r_rptr == i_ctl.row_last) ? '0 : r_rptr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pptr <= '0;
            r_rptr <= '0;
        end else begin
            r_pptr <= n_pptr;
            r_rptr <= n_rptr;
        end
    end

    // plane ring (n*(n+1) long): {prev in, row-below tap, curr in}
    assign plane_wd = {i_prev, row_rd[2*VB-1:VB], i_curr};
    // row ring (n long): {prev from plane ring, col-below tap, row-above tap}
    assign row_wd   = {plane_rd[3*VB-1:2*VB], r_dn_col, plane_rd[VB-1:0]};

    wss_ram #(
        .WIDTH (3 * VB),
        .DEPTH (wss_pkg::PLEN_MAX)
    ) u_plane_ram (
        .i_clk   (i_clk),
        .i_we    (i_ctl.shift),
        .i_waddr (r_pptr),
        .i_wdata (plane_wd),
        .i_raddr (n_pptr),
        .o_rdata (plane_rd)
    );

    wss_ram #(
        .WIDTH (3 * VB),
        .DEPTH (wss_pkg::GRID_MAX)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (i_ctl.shift),
        .i_waddr (r_rptr),
        .i_wdata (row_wd),
        .i_raddr (n_rptr),
        .o_rdata (row_rd)
    );

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_center <= row_rd[VB-1:0];
            r_dn_col <= r_center;
            r_prev_q <= row_rd[3*VB-1:2*VB];
        end
    end

    assign o_taps.up_plane = i_curr;
    assign o_taps.up_row   = plane_rd[VB-1:0];
    assign o_taps.up_col   = row_rd[VB-1:0];
    assign o_taps.center   = r_center;
    assign o_taps.dn_col   = r_dn_col;
    assign o_taps.dn_row   = row_rd[2*VB-1:VB];
    assign o_taps.dn_plane = plane_rd[2*VB-1:VB];
    assign o_taps.prev     = r_prev_q;

endmodule

`default_nettype wire

// File: rtl/wss_calc.sv
`default_nettype none

// Six-stage elastic update pipeline; the last stage is the output register.
module wss_calc (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  wss_pkg::t_taps                   i_taps,
    input  logic                             i_face,
    input  logic                             i_last,
    input  logic [wss_pkg::COEF_BITS-1:0]    i_coef,
    input  logic                             i_first,
    output logic                             o_valid,
    input  logic                             i_ready,
    output wss_pkg::t_value                  o_value,
    output logic                             o_last
);

    localparam int NST = 6;

    logic [NST-1:0] r_vld;
    logic [NST-1:0] ld;
    logic [NST-1:0] r_face, r_last;

    logic signed [wss_pkg::PAIR_W-1:0] r1_col, r1_row, r1_pln;
    wss_pkg::t_value                   r1_c, r1_p;
    logic signed [wss_pkg::SUM_W-1:0]  r2_sum, r2_c6;
    logic signed [wss_pkg::BASE_W-1:0] r2_base, r3_base, r4_base, r5_base;
    logic signed [wss_pkg::LAP_W-1:0]  r3_lap;
    logic signed [wss_pkg::PROD_W-1:0] r4_prod;
    logic signed [wss_pkg::PROD_W-1:0] n5_t, n5_rnd;
    logic signed [wss_pkg::R_W-1:0]    r5_r;
    logic signed [wss_pkg::ACC_W-1:0]  n6_acc;
    wss_pkg::t_value                   r6_value, n6_value;

    always_comb begin
        ld[NST-1] = !r_vld[NST-1] || i_ready;
        for (int s = NST - 2; s >= 0; s--) begin
            ld[s] = !r_vld[s] || ld[s+1];
        end
    end

    assign o_ready = ld[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (ld[0]) r_vld[0] <= i_valid;
            for (int s = 1; s < NST; s++) begin
                if (ld[s]) r_vld[s] <= r_vld[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld[0]) begin
            r_face[0] <= i_face;
            r_last[0] <= i_last;
        end
        for (int s = 1; s < NST; s++) begin
            if (ld[s]) begin
                r_face[s] <= r_face[s-1];
                r_last[s] <= r_last[s-1];
            end
        end
    end

    // stage 1: pair the opposite neighbors
    always_ff @(posedge i_clk) begin
        if (ld[0]) begin
            r1_col <= wss_pkg::PAIR_W'(i_taps.up_col) + wss_pkg::PAIR_W'(i_taps.dn_col);
            r1_row <= wss_pkg::PAIR_W'(i_taps.up_row) + wss_pkg::PAIR_W'(i_taps.dn_row);
            r1_pln <= wss_pkg::PAIR_W'(i_taps.up_plane) + wss_pkg::PAIR_W'(i_taps.dn_plane);
            r1_c   <= i_taps.center;
            r1_p   <= i_taps.prev;
        end
    end

    // stage 2: neighbor sum, 6c, and the part that does not scale with coef
    always_ff @(posedge i_clk) begin
        if (ld[1]) begin
            r2_sum <= wss_pkg::SUM_W'(r1_col) + wss_pkg::SUM_W'(r1_row)
                      + wss_pkg::SUM_W'(r1_pln);
            r2_c6  <= (wss_pkg::SUM_W'(r1_c) <<< 2) + (wss_pkg::SUM_W'(r1_c) <<< 1);
            if (i_first) begin
                r2_base <= wss_pkg::BASE_W'(r1_c);
            end else begin
                r2_base <= (wss_pkg::BASE_W'(r1_c) <<< 1) - wss_pkg::BASE_W'(r1_p);
            end
        end
    end

    // stage 3: laplacian
    always_ff @(posedge i_clk) begin
        if (ld[2]) begin
            r3_lap  <= wss_pkg::LAP_W'(r2_sum) - wss_pkg::LAP_W'(r2_c6);
            r3_base <= r2_base;
        end
    end

    // stage 4: scale by coef (unsigned)
    always_ff @(posedge i_clk) begin
        if (ld[3]) begin
            r4_prod <= r3_lap * $signed({1'b0, i_coef});
            r4_base <= r3_base;
        end
    end

    // stage 5: round half up; first step halves the coefficient
    always_comb begin
        n5_rnd = i_first ? wss_pkg::PROD_W'(2 ** wss_pkg::COEF_BITS)
                         : wss_pkg::PROD_W'(2 ** (wss_pkg::COEF_BITS - 1));
        n5_t   = r4_prod + n5_rnd;
    end

    always_ff @(posedge i_clk) begin
        if (ld[4]) begin
            if (i_first) begin
                r5_r <= wss_pkg::R_W'(n5_t >>> (wss_pkg::COEF_BITS + 1));
            end else begin
                r5_r <= wss_pkg::R_W'(n5_t >>> wss_pkg::COEF_BITS);
            end
            r5_base <= r4_base;
        end
    end

    // stage 6: final add and saturation; faces are forced to zero
    always_comb begin
        n6_acc = wss_pkg::ACC_W'(r5_base) + wss_pkg::ACC_W'(r5_r);
        if (r_face[4]) begin
            n6_value = '0;
        end else if (n6_acc > wss_pkg::ACC_W'(wss_pkg::VALUE_MAX)) begin
            n6_value = wss_pkg::VALUE_MAX;
        end else if (n6_acc < wss_pkg::ACC_W'(wss_pkg::VALUE_MIN)) begin
            n6_value = wss_pkg::VALUE_MIN;
        end else begin
            n6_value = wss_pkg::VALUE_BITS'(n6_acc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld[5]) begin
            r6_value <= n6_value;
        end
    end

    assign o_valid = r_vld[NST-1];
    assign o_value = r6_value;
    assign o_last  = r_last[NST-1];

endmodule

`default_nettype wire

// File: rtl/wave_stencil_step.sv
`default_nettype none

// One leapfrog time step of the 3D wave equation with a 7-point stencil on a
// cube of (n+1)^3 points, n = grid_n (values below 2 act as 2). Points enter in
// raster order (plane, row, column) and the block takes one point per clock
// unless output back-pressure stalls it; the rate is set by the plane delay
// ring, one n*(n+1) x 96-bit RAM written and read once per transfer, backed by
// an n-entry row ring. The result for point q leaves once point q+(n+1)^2 has
// been taken, so after the last grid point the source sends (n+1)^2 padding
// items of any value to flush the step; the last result carries tlast and the
// next item starts a new step. Face points give zero. The rings hold no reset
// contents and need no clearing pass. Write the registers only while the block
// is idle; writing grid_n restarts the step.
module wave_stencil_step (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // [31:0] curr_value, [63:32] prev_value
    input  logic [wss_pkg::IN_TDATA_W-1:0]       i_s_axis_tdata,
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    // [31:0] next_value
    output logic [wss_pkg::OUT_TDATA_W-1:0]      o_m_axis_tdata,
    output logic                                 o_m_axis_tlast,
    input  logic                                 i_cfg_we,
    input  logic [wss_pkg::CFG_INDEX_BITS-1:0]   i_cfg_index,
    input  logic [wss_pkg::CFG_DATA_BITS-1:0]    i_cfg_data
);

    localparam int VB = wss_pkg::VALUE_BITS;
    localparam int AW = wss_pkg::AXIS_W;

    logic [AW-1:0]                  r_n, n_n;
    logic [wss_pkg::FILL_W-1:0]     r_plane_last, n_plane_last;
    logic [wss_pkg::PLEN_W-1:0]     r_plen_last, n_plen_last;
    logic [wss_pkg::ROW_W-1:0]      r_row_last, n_row_last;
    logic [wss_pkg::COEF_BITS-1:0]  r_coef, n_coef;
    logic                           r_first, n_first;
    logic [wss_pkg::FILL_W-1:0]     r_fill, n_fill;
    logic                           r_primed, n_primed;
    logic [AW-1:0]                  r_i, r_j, r_k, n_i, n_j, n_k;
    logic [AW:0]                    cfg_m;
    logic [2*AW+1:0]                cfg_sq, cfg_nm;
    logic [AW-1:0]                  cfg_n;
    logic                           grid_wr;

    logic                           shift;
    logic                           calc_ready;
    logic                           face, last;
    wss_pkg::t_win_ctl              win_ctl;
    wss_pkg::t_taps                 taps;
    wss_pkg::t_value                out_value;

    assign o_s_axis_tready = calc_ready || !r_primed;
    assign shift           = i_s_axis_tvalid && o_s_axis_tready;

    assign face = (r_i == '0) || (r_i == r_n) || (r_j == '0) || (r_j == r_n)
                  || (r_k == '0) || (r_k == r_n);
    assign last = (r_i == r_n) && (r_j == r_n) && (r_k == r_n);

    // configuration decode and derived geometry
    always_comb begin
        n_n          = r_n;
        n_plane_last = r_plane_last;
        n_plen_last  = r_plen_last;
        n_row_last   = r_row_last;
        n_coef       = r_coef;
        n_first      = r_first;
        grid_wr      = 1'b0;
        cfg_n        = wss_pkg::eff_grid(i_cfg_data[wss_pkg::GRID_BITS-1:0]);
        cfg_m        = {1'b0, cfg_n} + 1'b1;
        cfg_sq       = cfg_m * cfg_m;
        cfg_nm       = cfg_n * cfg_m;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                wss_pkg::CFG_GRID_N: begin
                    grid_wr      = 1'b1;
                    n_n          = cfg_n;
                    n_plane_last = wss_pkg::FILL_W'(cfg_sq - 1'b1);
                    n_plen_last  = wss_pkg::PLEN_W'(cfg_nm - 1'b1);
                    n_row_last   = wss_pkg::ROW_W'(cfg_n - 1'b1);
                end
                wss_pkg::CFG_COEF: begin
                    n_coef = i_cfg_data[wss_pkg::COEF_BITS-1:0];
                end
                wss_pkg::CFG_FIRST_STEP: begin
                    n_first = i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    // warm-up count for the first plane, then output scan position
    always_comb begin
        n_fill   = r_fill;
        n_primed = r_primed;
        n_i      = r_i;
        n_j      = r_j;
        n_k      = r_k;
        if (grid_wr) begin
            n_fill   = '0;
            n_primed = 1'b0;
            n_i      = '0;
            n_j      = '0;
            n_k      = '0;
        end else if (shift) begin
            if (!r_primed) begin
                if (r_fill == r_plane_last) begin
                    n_fill   = '0;
                    n_primed = 1'b1;
                end else begin
                    n_fill = r_fill + 1'b1;
                end
            end else if (last) begin
                n_primed = 1'b0;
                n_i      = '0;
                n_j      = '0;
                n_k      = '0;
            end else if (r_k == r_n) begin
                n_k = '0;
                if (r_j == r_n) begin
                    n_j = '0;
                    n_i = r_i + 1'b1;
                end else begin
                    n_j = r_j + 1'b1;
                end
            end else begin
                n_k = r_k + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n          <= AW'(wss_pkg::RESET_N);
            r_plane_last <= wss_pkg::FILL_W'(wss_pkg::RESET_PLANE_LAST);
            r_plen_last  <= wss_pkg::PLEN_W'(wss_pkg::RESET_PLEN_LAST);
            r_row_last   <= wss_pkg::ROW_W'(wss_pkg::RESET_ROW_LAST);
            r_coef       <= '0;
            r_first      <= 1'b0;
            r_fill       <= '0;
            r_primed     <= 1'b0;
            r_i          <= '0;
            r_j          <= '0;
            r_k          <= '0;
        end else begin
            r_n          <= n_n;
            r_plane_last <= n_plane_last;
            r_plen_last  <= n_plen_last;
            r_row_last   <= n_row_last;
            r_coef       <= n_coef;
            r_first      <= n_first;
            r_fill       <= n_fill;
            r_primed     <= n_primed;
            r_i          <= n_i;
            r_j          <= n_j;
            r_k          <= n_k;
        end
    end

    assign win_ctl.shift      = shift;
    assign win_ctl.clear      = grid_wr;
    assign win_ctl.plane_last = r_plen_last;
    assign win_ctl.row_last   = r_row_last;

    wss_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (win_ctl),
        .i_curr  (i_s_axis_tdata[VB-1:0]),
        .i_prev  (i_s_axis_tdata[2*VB-1:VB]),
        .o_taps  (taps)
    );

    wss_calc u_calc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (shift && r_primed),
        .o_ready (calc_ready),
        .i_taps  (taps),
        .i_face  (face),
        .i_last  (last),
        .i_coef  (r_coef),
        .i_first (r_first),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_value (out_value),
        .o_last  (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = wss_pkg::OUT_TDATA_W'($unsigned(out_value));

endmodule

`default_nettype wire

// File: rtl/wss_checker.sv
`default_nettype none

module wss_sva (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             o_s_axis_tready,
    input logic                             o_m_axis_tvalid,
    input logic                             i_m_axis_tready,
    input logic [wss_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata,
    input logic                             o_m_axis_tlast
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid right after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("stalled result changed");

    // the final point is a corner, so it is always zero
    a_last_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tlast |-> o_m_axis_tdata == '0)
        else $error("last point is not zero");

    // with the output register empty nothing downstream can hold off a transfer
    a_ready_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input stalled while output side is empty");

endmodule

bind wave_stencil_step wss_sva u_wss_sva (.*);

`default_nettype wire
